// ----- design/yuy2rgb_pkg.sv -----
// yuy2rgb_pkg: fixed-point constants and channel helper for the yuy2 to rgb24 converter
// no dependencies; imported by yuy2_to_rgb24_converter
`default_nettype none

package yuy2rgb_pkg;

  // coefficient fraction bits (q2.f format), valid range 10 to 18
  localparam int COEF_FRAC_BITS = 14;

  // coefficient width: sign, one integer bit and the fraction bits
  localparam int CoefW = COEF_FRAC_BITS + 2;
  // accumulator width: luma shifted up plus two chroma products, with headroom
  localparam int AccW  = COEF_FRAC_BITS + 11;

  localparam longint unsigned DecScale = 64'd10000000;

  // coefficient magnitudes, decimal constant times 2^f rounded to nearest
  localparam longint unsigned CrU =
    ((64'd9267     << COEF_FRAC_BITS) + DecScale / 2) / DecScale;
  localparam longint unsigned CrV =
    ((64'd14016868 << COEF_FRAC_BITS) + DecScale / 2) / DecScale;
  localparam longint unsigned CgU =
    ((64'd3436954  << COEF_FRAC_BITS) + DecScale / 2) / DecScale;
  localparam longint unsigned CgV =
    ((64'd7141690  << COEF_FRAC_BITS) + DecScale / 2) / DecScale;
  localparam longint unsigned CbU =
    ((64'd17721604 << COEF_FRAC_BITS) + DecScale / 2) / DecScale;
  localparam longint unsigned CbV =
    ((64'd9902     << COEF_FRAC_BITS) + DecScale / 2) / DecScale;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [AccW-1:0]  acc_t;

  // signed coefficients as applied to (u-128) and (v-128)
  localparam coef_t KRU = -coef_t'(CrU);
  localparam coef_t KRV =  coef_t'(CrV);
  localparam coef_t KGU = -coef_t'(CgU);
  localparam coef_t KGV = -coef_t'(CgV);
  localparam coef_t KBU =  coef_t'(CbU);
  localparam coef_t KBV =  coef_t'(CbV);

  // one channel: luma plus two products, floored and clamped to 0..255
  function automatic logic [7:0] sat_chan(input logic [7:0] y, input acc_t pu,
                                          input acc_t pv);
    acc_t acc;
    acc_t q;
    acc = signed'(AccW'(y) << COEF_FRAC_BITS) + pu + pv;
    q   = acc >>> COEF_FRAC_BITS;
    if (acc[AccW-1]) begin
      sat_chan = 8'd0;
    end else if (|q[AccW-1:8]) begin
      sat_chan = 8'd255;
    end else begin
      sat_chan = q[7:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/yuy2_to_rgb24_converter.sv -----
// yuy2_to_rgb24_converter: yuy2 macropixel to two rgb888 pixels
// depends on yuy2rgb_pkg (coefficients, widths, channel clamp)
// an accepted item passes the input register, then the result register, before the out_valid strobe
// throughput: one item per cycle, set by a single input register and result register
// busy is high only while rst_n is low; reset clears the valid pipeline, no payload reset
`default_nettype none

module yuy2_to_rgb24_converter
  import yuy2rgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_y_first,
  input  wire logic [7:0] in_u_shared,
  input  wire logic [7:0] in_y_second,
  input  wire logic [7:0] in_v_shared,
  input  wire logic       in_frame_end_in,
  output logic            out_valid,
  output logic [7:0]      out_red_first,
  output logic [7:0]      out_green_first,
  output logic [7:0]      out_blue_first,
  output logic [7:0]      out_red_second,
  output logic [7:0]      out_green_second,
  output logic [7:0]      out_blue_second,
  output logic            out_frame_end_out
);

  // the pipeline never stalls, so items are refused only during reset
  assign busy = ~rst_n;

  logic       accept;
  assign accept = start & ~busy;

  // input register stage
  logic       in_vld_r;
  logic [7:0] y0_r, y1_r, u_r, v_r;
  logic       fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y0_r <= in_y_first;
      y1_r <= in_y_second;
      u_r  <= in_u_shared;
      v_r  <= in_v_shared;
      fe_r <= in_frame_end_in;
    end
  end

  // chroma offsets: x - 128 is the byte with its top bit flipped, read as signed
  logic signed [7:0] du, dv;
  assign du = signed'({~u_r[7], u_r[6:0]});
  assign dv = signed'({~v_r[7], v_r[6:0]});

  // chroma products, shared by both pixels of the pair
  acc_t ru, rv, gu, gv, bu, bv;
  assign ru = acc_t'(KRU) * acc_t'(du);
  assign rv = acc_t'(KRV) * acc_t'(dv);
  assign gu = acc_t'(KGU) * acc_t'(du);
  assign gv = acc_t'(KGV) * acc_t'(dv);
  assign bu = acc_t'(KBU) * acc_t'(du);
  assign bv = acc_t'(KBV) * acc_t'(dv);

  // next values of the result register
  logic [7:0] r0_nxt, g0_nxt, b0_nxt, r1_nxt, g1_nxt, b1_nxt;
  always_comb begin
    r0_nxt = sat_chan(y0_r, ru, rv);
    g0_nxt = sat_chan(y0_r, gu, gv);
    b0_nxt = sat_chan(y0_r, bu, bv);
    r1_nxt = sat_chan(y1_r, ru, rv);
    g1_nxt = sat_chan(y1_r, gu, gv);
    b1_nxt = sat_chan(y1_r, bu, bv);
  end

  // result register stage; strobe lasts exactly one cycle per item
  logic       out_vld_r;
  logic [7:0] r0_r, g0_r, b0_r, r1_r, g1_r, b1_r;
  logic       fe_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      r0_r     <= r0_nxt;
      g0_r     <= g0_nxt;
      b0_r     <= b0_nxt;
      r1_r     <= r1_nxt;
      g1_r     <= g1_nxt;
      b1_r     <= b1_nxt;
      fe_out_r <= fe_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_red_first     = r0_r;
  assign out_green_first   = g0_r;
  assign out_blue_first    = b0_r;
  assign out_red_second    = r1_r;
  assign out_green_second  = g1_r;
  assign out_blue_second   = b1_r;
  assign out_frame_end_out = fe_out_r;

  // every accepted item gives a strobe once it has passed both register stages
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted item gave no result strobe");

  // no strobe without an accepted item behind it in the register stages
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result strobe without an accepted item");

  // frame end flag travels with its item
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_end_out == $past(in_frame_end_in, 2)))
    else $error("frame end flag out of step with its item");

  // equal luma in a pair must give equal pixels, as chroma is shared
  a_pair_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_y_first == in_y_second, 2)) |->
      (out_red_first == out_red_second && out_green_first == out_green_second &&
       out_blue_first == out_blue_second))
    else $error("pixel pair differs despite equal luma");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for yuy2_to_rgb24_converter: directed macropixel table, then random items
// checks each pixel pair against its own fixed-point colour predictor or a typed-in table row; needs only the rtl
`timescale 1ns / 100ps

module testbench;

  // q2.14 coefficients, scaled from the decimal constants with round-to-nearest
  localparam int      FracBits = 14;
  localparam longint  DecScale = 10000000;
  localparam int      QuietLimit = 1000;
  localparam int      DrainCycles = 6;

  function automatic longint scaled_coef(input longint magnitude_e7);
    return ((magnitude_e7 <<< FracBits) + DecScale / 2) / DecScale;
  endfunction

  localparam longint RedFromU   = -scaled_coef(9267);
  localparam longint RedFromV   =  scaled_coef(14016868);
  localparam longint GreenFromU = -scaled_coef(3436954);
  localparam longint GreenFromV = -scaled_coef(7141690);
  localparam longint BlueFromU  =  scaled_coef(17721604);
  localparam longint BlueFromV  =  scaled_coef(9902);

  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
    logic       fe;
  } macropixel_t;

  typedef struct packed {
    logic [7:0] r0;
    logic [7:0] g0;
    logic [7:0] b0;
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
    logic       fe;
  } pixel_pair_t;

  // where a directed row takes its expected pixel pair from
  typedef enum bit {FROM_PREDICTOR, FROM_TABLE} want_src_t;

  typedef struct packed {
    macropixel_t px;
    want_src_t   src;
    pixel_pair_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [7:0] in_y_first = '0;
  logic [7:0] in_u_shared = '0;
  logic [7:0] in_y_second = '0;
  logic [7:0] in_v_shared = '0;
  logic       in_frame_end_in = 1'b0;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_red_first;
  logic [7:0] out_green_first;
  logic [7:0] out_blue_first;
  logic [7:0] out_red_second;
  logic [7:0] out_green_second;
  logic [7:0] out_blue_second;
  logic       out_frame_end_out;

  pixel_pair_t pending_pairs[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  yuy2_to_rgb24_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_y_first        (in_y_first),
    .in_u_shared       (in_u_shared),
    .in_y_second       (in_y_second),
    .in_v_shared       (in_v_shared),
    .in_frame_end_in   (in_frame_end_in),
    .out_valid         (out_valid),
    .out_red_first     (out_red_first),
    .out_green_first   (out_green_first),
    .out_blue_first    (out_blue_first),
    .out_red_second    (out_red_second),
    .out_green_second  (out_green_second),
    .out_blue_second   (out_blue_second),
    .out_frame_end_out (out_frame_end_out)
  );

  always #6 clk = ~clk;

  // one colour channel: exact accumulator, floor by the shift, clamp to a byte
  function automatic logic [7:0] clamp_channel(input logic [7:0] y, input longint ku,
                                               input longint du, input longint kv,
                                               input longint dv);
    longint acc;
    longint q;
    acc = (longint'(y) <<< FracBits) + ku * du + kv * dv;
    if (acc < 0) return 8'd0;
    q = acc >>> FracBits;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // both pixels share the chroma pair; the frame end flag is copied through
  function automatic pixel_pair_t rgb_pair_of(input macropixel_t m);
    pixel_pair_t p;
    longint      du;
    longint      dv;
    du   = longint'(m.u) - 128;
    dv   = longint'(m.v) - 128;
    p.r0 = clamp_channel(m.y0, RedFromU, du, RedFromV, dv);
    p.g0 = clamp_channel(m.y0, GreenFromU, du, GreenFromV, dv);
    p.b0 = clamp_channel(m.y0, BlueFromU, du, BlueFromV, dv);
    p.r1 = clamp_channel(m.y1, RedFromU, du, RedFromV, dv);
    p.g1 = clamp_channel(m.y1, GreenFromU, du, GreenFromV, dv);
    p.b1 = clamp_channel(m.y1, BlueFromU, du, BlueFromV, dv);
    p.fe = m.fe;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // biased towards 0, 255 and 128 so the clamps and neutral chroma are hit often
  function automatic logic [7:0] random_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // present one item, with random idle cycles ahead of it, and hold it until taken;
  // the expectation is queued at the accepting edge
  task automatic send_macropixel(input macropixel_t m, input want_src_t src,
                                 input pixel_pair_t want, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_y_first      <= m.y0;
    in_u_shared     <= m.u;
    in_y_second     <= m.y1;
    in_v_shared     <= m.v;
    in_frame_end_in <= m.fe;
    do @(posedge clk); while (busy);
    pending_pairs.push_back(src == FROM_TABLE ? want : rgb_pair_of(m));
  endtask

  // stimulus: reset, directed table, then random phases with different sender gaps
  initial begin
    dir_row_t    dir_rows [15];
    int          idle_pcts [4];
    macropixel_t m;

    dir_rows = '{
      // neutral chroma: channels equal luma, so the result can be typed in
      '{'{8'd0,   8'd128, 8'd0,   8'd128, 1'b0}, FROM_TABLE,
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
      '{'{8'd255, 8'd128, 8'd255, 8'd128, 1'b1}, FROM_TABLE,
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
      '{'{8'd128, 8'd128, 8'd1,   8'd128, 1'b0}, FROM_TABLE,
        '{8'd128, 8'd128, 8'd128, 8'd1,   8'd1,   8'd1,   1'b0}},
      // chroma extremes: negative sums clamp to zero, large ones to full scale
      '{'{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd0,   8'd255, 8'd255, 8'd0,   1'b1}, FROM_PREDICTOR, '0},
      '{'{8'd255, 8'd0,   8'd0,   8'd255, 1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd128, 8'd255, 8'd128, 8'd128, 1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd128, 8'd0,   8'd128, 8'd128, 1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd128, 8'd128, 8'd128, 8'd255, 1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd128, 8'd128, 8'd128, 8'd0,   1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd0,   8'd128, 8'd255, 8'd255, 1'b0}, FROM_PREDICTOR, '0},
      '{'{8'd255, 8'd0,   8'd0,   8'd0,   1'b1}, FROM_PREDICTOR, '0},
      // alternating bit patterns so every input bit toggles
      '{'{8'hAA,  8'h55,  8'h55,  8'hAA,  1'b0}, FROM_PREDICTOR, '0},
      '{'{8'h55,  8'hAA,  8'hAA,  8'h55,  1'b1}, FROM_PREDICTOR, '0}
    };
    // no gaps, heavy gaps, light gaps, then back to back again
    idle_pcts = '{0, 45, 6, 0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_macropixel(dir_rows[i].px, dir_rows[i].src, dir_rows[i].want, 0);

    foreach (idle_pcts[ph]) begin
      repeat (400) begin
        m.y0 = random_byte();
        m.u  = random_byte();
        m.y1 = random_byte();
        m.v  = random_byte();
        // roughly one frame end in sixteen macropixels
        m.fe = ($urandom_range(15) == 0);
        send_macropixel(m, FROM_PREDICTOR, '0, idle_pcts[ph]);
      end
    end
    start <= 1'b0;

    // drain: the watchdog below catches a result that never comes
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: the strobe lasts one cycle, so every valid edge is a result
  always @(posedge clk) begin
    pixel_pair_t want;
    if (rst_n && out_valid) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_pairs.pop_front();
        if (out_red_first !== want.r0)
          report_mismatch("red_first", int'(out_red_first), int'(want.r0));
        if (out_green_first !== want.g0)
          report_mismatch("green_first", int'(out_green_first), int'(want.g0));
        if (out_blue_first !== want.b0)
          report_mismatch("blue_first", int'(out_blue_first), int'(want.b0));
        if (out_red_second !== want.r1)
          report_mismatch("red_second", int'(out_red_second), int'(want.r1));
        if (out_green_second !== want.g1)
          report_mismatch("green_second", int'(out_green_second), int'(want.g1));
        if (out_blue_second !== want.b1)
          report_mismatch("blue_second", int'(out_blue_second), int'(want.b1));
        if (out_frame_end_out !== want.fe)
          report_mismatch("frame_end_out", int'(out_frame_end_out), int'(want.fe));
      end
    end
  end

  // watchdog: too long without an item taken or a result given ends the run
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
design/yuy2rgb_pkg.sv
design/yuy2_to_rgb24_converter.sv
sim/testbench.sv
